// File: sv/utf8_stream_decoder_top_assert.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
// Expects signals named clock and reset in the including module.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// Check post in the same cycle as pre.
`define USD_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check post in the cycle after pre.
`define USD_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/usd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every other file of the block but the assertion header.
`default_nettype none

package usd_pkg;

   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 31;
   localparam int STATUS_W    = 2;
   localparam int PEND_W      = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = QUEUE_AW + 1;

   // Byte class as seen without decoder state
   typedef enum logic [1:0] {
      KIND_ASCII   = 2'd0,
      KIND_LEAD    = 2'd1,
      KIND_CONT    = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CHAR     = 2'd0,
      ST_BAD_LEAD = 2'd1,
      ST_BAD_CONT = 2'd2,
      ST_TRUNC    = 2'd3
   } status_type;

   typedef struct packed {
      kind_type            kind;
      logic [PEND_W-1:0]   lead_count;  // continuation bytes a lead asks for
      logic [CODE_W-1:0]   lead_bits;   // lead payload already placed
      logic [6:0]          data;        // low seven bits of the byte
      logic                last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

`default_nettype wire

// File: sv/usd_ifs.sv
// Valid/ready channel interfaces for the UTF-8 stream decoder.
// Depends on usd_pkg for payload widths.
`default_nettype none

interface usd_req_if;
   import usd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              end_of_text;

   modport source (output valid, output byte_value, output end_of_text, input ready);
   modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface usd_rsp_if;
   import usd_pkg::*;

   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   code_point;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

`default_nettype wire

// File: sv/usd_front.sv
// Front end: takes input bytes and classifies them by bit pattern.
// Depends on usd_pkg and usd_req_if.
`default_nettype none

module usd_front (
   usd_req_if.sink           req,
   input  logic              q_full,
   output usd_pkg::push_type push
);
   import usd_pkg::*;

   logic [BYTE_W-1:0] b;
   entry_type         entry;

   assign b = req.byte_value;
   assign req.ready = !q_full;

   always_comb begin
      entry.kind       = KIND_INVALID;
      entry.lead_count = '0;
      entry.lead_bits  = '0;
      entry.data       = b[6:0];
      entry.last       = req.end_of_text;
      // Lead payload lands at the top of a code point of its length
      priority if (!b[7]) begin
         entry.kind = KIND_ASCII;
      end else if (b[7:5] == 3'b110) begin
         entry.kind       = KIND_LEAD;
         entry.lead_count = 3'd1;
         entry.lead_bits  = CODE_W'(b[4:0]) << 6;
      end else if (b[7:4] == 4'b1110) begin
         entry.kind       = KIND_LEAD;
         entry.lead_count = 3'd2;
         entry.lead_bits  = CODE_W'(b[3:0]) << 12;
      end else if (b[7:3] == 5'b11110) begin
         entry.kind       = KIND_LEAD;
         entry.lead_count = 3'd3;
         entry.lead_bits  = CODE_W'(b[2:0]) << 18;
      end else if (b[7:2] == 6'b111110) begin
         entry.kind       = KIND_LEAD;
         entry.lead_count = 3'd4;
         entry.lead_bits  = CODE_W'(b[1:0]) << 24;
      end else if (b[7:1] == 7'b1111110) begin
         entry.kind       = KIND_LEAD;
         entry.lead_count = 3'd5;
         entry.lead_bits  = CODE_W'(b[0]) << 30;
      end else if (b[7:6] == 2'b10) begin
         entry.kind = KIND_CONT;
      end else begin
         entry.kind = KIND_INVALID;
      end
   end

   assign push.valid = req.valid && req.ready;
   assign push.entry = entry;

endmodule

`default_nettype wire

// File: sv/usd_queue.sv
// Short FIFO of classified bytes between the front end and the decoder.
// Depends on usd_pkg.
`default_nettype none

module usd_queue (
   input  logic              clock,
   input  logic              reset,
   input  usd_pkg::push_type push,
   input  logic              pop,
   output logic              q_full,
   output usd_pkg::head_type head
);
   import usd_pkg::*;

   `include "utf8_stream_decoder_top_assert.svh"

   entry_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign q_full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `USD_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
   `USD_ASSERT_NOW(a_pop_has_data, pop, count_ff != '0, "pop from empty queue")
   `USD_ASSERT_NEXT(a_count_up, push.valid && !pop, count_ff == $past(count_ff) + CNT_W'(1),
                    "queue count did not advance on push")

endmodule

`default_nettype wire

// File: sv/usd_back.sv
// Back end: holds the pending count and accumulator, builds code points and
// status results, and drives the registered result channel. Depends on usd_pkg.
`default_nettype none

module usd_back (
   input  logic              clock,
   input  logic              reset,
   input  usd_pkg::head_type head,
   output logic              pop,
   usd_rsp_if.source         rsp
);
   import usd_pkg::*;

   `include "utf8_stream_decoder_top_assert.svh"

   logic [PEND_W-1:0] pending_ff, pending_in;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   status_type        status_ff, status_in;

   logic              emit;
   logic [PEND_W-1:0] pend_dec;
   logic [CODE_W-1:0] cont_place;
   logic [CODE_W-1:0] acc_merge;

   // Take the next transaction whenever the result register is free or draining
   assign pop = head.valid && (!rsp_valid_ff || rsp.ready);

   assign pend_dec  = pending_ff - PEND_W'(1);
   assign acc_merge = acc_ff | cont_place;

   always_comb begin
      unique case (pend_dec)
         3'd0:    cont_place = CODE_W'(head.entry.data[5:0]);
         3'd1:    cont_place = CODE_W'(head.entry.data[5:0]) << 6;
         3'd2:    cont_place = CODE_W'(head.entry.data[5:0]) << 12;
         3'd3:    cont_place = CODE_W'(head.entry.data[5:0]) << 18;
         default: cont_place = CODE_W'(head.entry.data[5:0]) << 24;
      endcase
   end

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      emit       = 1'b0;
      code_in    = '0;
      status_in  = ST_CHAR;
      if (pop) begin
         if (pending_ff == '0) begin
            unique case (head.entry.kind)
               KIND_ASCII: begin
                  emit    = 1'b1;
                  code_in = CODE_W'(head.entry.data);
               end
               KIND_LEAD: begin
                  if (head.entry.last) begin
                     emit      = 1'b1;
                     status_in = ST_TRUNC;
                  end else begin
                     pending_in = head.entry.lead_count;
                     acc_in     = head.entry.lead_bits;
                  end
               end
               default: begin
                  emit      = 1'b1;
                  status_in = ST_BAD_LEAD;
               end
            endcase
         end else if (head.entry.kind != KIND_CONT) begin
            // Drop the partial sequence and consume the byte
            emit       = 1'b1;
            status_in  = ST_BAD_CONT;
            pending_in = '0;
            acc_in     = '0;
         end else if (pend_dec == '0) begin
            emit       = 1'b1;
            code_in    = acc_merge;
            pending_in = '0;
            acc_in     = '0;
         end else if (head.entry.last) begin
            emit       = 1'b1;
            status_in  = ST_TRUNC;
            pending_in = '0;
            acc_in     = '0;
         end else begin
            pending_in = pend_dec;
            acc_in     = acc_merge;
         end
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff   <= code_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.code_point = code_ff;
   assign rsp.status     = STATUS_W'(status_ff);

   `USD_ASSERT_NOW(a_pend_range, 1'b1, pending_ff <= PEND_W'(5), "pending count out of range")
   `USD_ASSERT_NEXT(a_eot_clear, pop && head.entry.last, pending_ff == '0,
                    "state not cleared after end of text")
   `USD_ASSERT_NOW(a_err_zero, rsp_valid_ff && status_ff != ST_CHAR, code_ff == '0,
                   "error result carries nonzero code point")
   `USD_ASSERT_NEXT(a_ascii_emit,
                    pop && pending_ff == '0 && head.entry.kind == KIND_ASCII,
                    rsp_valid_ff && status_ff == ST_CHAR, "single-byte character not emitted")

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder_top.sv
// UTF-8 stream decoder, original 1-to-6-byte form. Takes one byte per
// transaction on req and gives at most one result per byte on rsp: a code
// point with status 0 when a sequence completes, or a zero code point with
// status 1 (invalid lead byte), 2 (bad continuation, partial sequence dropped)
// or 3 (sequence cut short by end_of_text). Sustained rate is one byte per
// clock while rsp is not held off; the decoder state update is registered.
// A byte is written into the four-entry classified-byte queue when accepted,
// is decoded from the head of that queue, and its result, if any, is registered
// in the result register and held there until taken. req.ready drops only
// when that queue is full, which happens when rsp is held off.
`default_nettype none

module utf8_stream_decoder_top (
   input  logic      clock,
   input  logic      reset,
   usd_req_if.sink   req,
   usd_rsp_if.source rsp
);
   import usd_pkg::*;

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   usd_front u_front (
      .req    (req),
      .q_full (q_full),
      .push   (push)
   );

   usd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .q_full (q_full),
      .head   (head)
   );

   usd_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire
